[hw/rtl/pkn_pkg.sv]
// Shared types and constants for the peak normalizer.
`default_nettype none

package pkn_pkg;

    localparam int SAMPLE_W    = 16;  // input sample width
    localparam int VALUE_W     = 17;  // stored value width, signed
    localparam int NORM_W      = 17;  // normalized output width, signed
    localparam int QUO_W       = 16;  // quotient bits, 0..32768
    localparam int COUNT_OUT_W = 13;  // reported sample count width

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_FETCH = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_LOAD  = 5'b00010,
        ST_READ  = 5'b00100,
        ST_SETUP = 5'b01000,
        ST_DIV   = 5'b10000
    } t_state;

endpackage

`default_nettype wire

[hw/rtl/pkn_divider.sv]
// Iterative restoring divider producing one quotient bit per cycle.
`default_nettype none

module pkn_divider (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [pkn_pkg::VALUE_W-1:0]   i_dividend,
    input  wire logic [pkn_pkg::VALUE_W-1:0]   i_divisor,
    output logic                               o_busy,
    output logic                               o_done,
    output logic [pkn_pkg::QUO_W-1:0]          o_quotient
);

    localparam int CNT_W = $clog2(pkn_pkg::QUO_W);
    localparam int REM_W = pkn_pkg::VALUE_W + 1;

    logic                          r_busy;
    logic                          r_done;
    logic [CNT_W-1:0]              r_cnt;
    logic [REM_W-1:0]              r_rem;
    logic [pkn_pkg::VALUE_W-1:0]   r_div;
    logic [pkn_pkg::QUO_W-1:0]     r_quo;

    logic                          w_ge;
    logic [REM_W-1:0]              w_rem_sub;

    // The dividend never exceeds the divisor, so the first step yields the
    // integer bit and the remaining steps shift in the fraction bits.
    always_comb begin
        w_ge      = (r_rem >= {1'b0, r_div});
        w_rem_sub = w_ge ? (r_rem - {1'b0, r_div}) : r_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(pkn_pkg::QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_dividend};
            r_div <= i_divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= {w_rem_sub[REM_W-2:0], 1'b0};
            r_quo <= {r_quo[pkn_pkg::QUO_W-2:0], w_ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("divider done held for more than one cycle");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a preceding run");
`endif

endmodule

`default_nettype wire

[hw/rtl/peak_normalizer.sv]
// Top level of the peak normalizer: sample store, min/max tracking, sequencer.
//
//  Channel   Direction  Handshake             Payload
//  command   in         start & !busy         i_req_type, i_left_sample,
//                                             i_right_sample, i_frame_last
//  result    out        o_done, one cycle     o_norm_sample, o_is_last, o_min_value,
//                                             o_max_value, o_sample_count, o_overflow
//  config    in         i_cfg_we              i_cfg_wdata (stereo mode)
//
// A load word holds busy high in its load state, so the next word waits until that state ends.
// A fetch word that yields a result passes through the store read, setup, 16 steps of the
// restoring divider, the divider's done pulse and the output register.
// A fetch word with nothing to return leaves busy low.
// Reset is synchronous and clears the set; the store contents are not cleared.
// The result receiver cannot stall; o_done marks each result for one cycle.
`default_nettype none

module peak_normalizer #(
    parameter int STORE_DEPTH = 4096
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic                                  i_cfg_we,
    input  wire logic                                  i_cfg_wdata,
    input  wire logic                                  i_req_type,
    input  wire logic signed [pkn_pkg::SAMPLE_W-1:0]   i_left_sample,
    input  wire logic signed [pkn_pkg::SAMPLE_W-1:0]   i_right_sample,
    input  wire logic                                  i_frame_last,
    output logic                                       o_done,
    output logic signed [pkn_pkg::NORM_W-1:0]          o_norm_sample,
    output logic                                       o_is_last,
    output logic signed [pkn_pkg::SAMPLE_W-1:0]        o_min_value,
    output logic [pkn_pkg::SAMPLE_W-1:0]               o_max_value,
    output logic [pkn_pkg::COUNT_OUT_W-1:0]            o_sample_count,
    output logic                                       o_overflow
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int VW = pkn_pkg::VALUE_W;

    pkn_pkg::t_state r_state;
    pkn_pkg::t_state n_state;

    logic                          r_stereo;
    logic signed [VW-1:0]          r_mem [STORE_DEPTH];
    logic signed [VW-1:0]          r_rd_data;
    logic signed [VW-1:0]          r_max;
    logic signed [VW-1:0]          r_min;
    logic [CW-1:0]                 r_wcount;
    logic [CW-1:0]                 r_rptr;
    logic                          r_closed;
    logic                          r_dropped;
    logic                          r_neg;
    logic signed [pkn_pkg::SAMPLE_W-1:0] r_left;
    logic signed [pkn_pkg::SAMPLE_W-1:0] r_right;
    logic                          r_last;

    logic                          r_done;
    logic signed [pkn_pkg::NORM_W-1:0] r_norm;
    logic                          r_is_last;

    logic                          w_accept;
    logic                          w_fetch_ok;
    logic signed [VW-1:0]          w_l_ext;
    logic signed [VW-1:0]          w_r_ext;
    logic [VW-1:0]                 w_l_mag;
    logic [VW-1:0]                 w_r_mag;
    logic [VW:0]                   w_mix_sum;
    logic signed [VW-1:0]          w_value;
    logic [CW-1:0]                 w_wc_base;
    logic signed [VW-1:0]          w_max_base;
    logic signed [VW-1:0]          w_min_base;
    logic                          w_drop_base;
    logic                          w_room;
    logic                          w_mem_we;
    logic [VW-1:0]                 w_pmin;
    logic [VW-1:0]                 w_peak;
    logic [VW-1:0]                 w_rd_mag;
    logic                          w_div_start;
    logic                          w_div_busy;
    logic                          w_div_done;
    logic [pkn_pkg::QUO_W-1:0]     w_quo;
    logic [pkn_pkg::NORM_W-1:0]    w_quo_ext;
    logic [31:0]                   w_cnt_ext;

    assign busy       = (r_state != pkn_pkg::ST_IDLE);
    assign w_accept   = start && !busy;
    assign w_fetch_ok = r_closed && (r_rptr < r_wcount);

    // Reduce a frame to one value and decide how the set bookkeeping moves.
    always_comb begin
        w_l_ext   = {r_left[pkn_pkg::SAMPLE_W-1], r_left};
        w_r_ext   = {r_right[pkn_pkg::SAMPLE_W-1], r_right};
        w_l_mag   = w_l_ext[VW-1] ? VW'(-w_l_ext) : VW'(w_l_ext);
        w_r_mag   = w_r_ext[VW-1] ? VW'(-w_r_ext) : VW'(w_r_ext);
        w_mix_sum = {1'b0, w_l_mag} + {1'b0, w_r_mag};
        w_value   = r_stereo ? signed'(w_mix_sum[VW:1]) : w_l_ext;

        // A load onto a closed set starts a fresh one.
        w_wc_base   = r_closed ? '0 : r_wcount;
        w_max_base  = r_closed ? '0 : r_max;
        w_min_base  = r_closed ? '0 : r_min;
        w_drop_base = r_closed ? 1'b0 : r_dropped;
        w_room      = (w_wc_base < CW'(STORE_DEPTH));
        w_mem_we    = (r_state == pkn_pkg::ST_LOAD) && w_room;
    end

    always_comb begin
        w_pmin   = VW'(-r_min);
        w_peak   = (w_pmin > VW'(r_max)) ? w_pmin : VW'(r_max);
        w_rd_mag = r_rd_data[VW-1] ? VW'(-r_rd_data) : VW'(r_rd_data);
        w_div_start = (r_state == pkn_pkg::ST_SETUP);
        w_quo_ext   = {1'b0, w_quo};
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pkn_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (i_req_type == pkn_pkg::REQ_LOAD) begin
                        n_state = pkn_pkg::ST_LOAD;
                    end else if (w_fetch_ok) begin
                        n_state = pkn_pkg::ST_READ;
                    end
                end
            end
            pkn_pkg::ST_LOAD:  n_state = pkn_pkg::ST_IDLE;
            pkn_pkg::ST_READ:  n_state = pkn_pkg::ST_SETUP;
            pkn_pkg::ST_SETUP: n_state = pkn_pkg::ST_DIV;
            pkn_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_state = pkn_pkg::ST_IDLE;
                end
            end
            default: n_state = pkn_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pkn_pkg::ST_IDLE;
            r_stereo  <= 1'b0;
            r_max     <= '0;
            r_min     <= '0;
            r_wcount  <= '0;
            r_rptr    <= '0;
            r_closed  <= 1'b0;
            r_dropped <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;
            if (i_cfg_we) begin
                r_stereo <= i_cfg_wdata;
            end
            if (r_state == pkn_pkg::ST_LOAD) begin
                r_rptr   <= '0;
                r_closed <= r_last;
                if (w_room) begin
                    r_wcount  <= w_wc_base + CW'(1);
                    r_max     <= (w_value > w_max_base) ? w_value : w_max_base;
                    r_min     <= (w_value < w_min_base) ? w_value : w_min_base;
                    r_dropped <= w_drop_base;
                end else begin
                    r_wcount  <= w_wc_base;
                    r_max     <= w_max_base;
                    r_min     <= w_min_base;
                    r_dropped <= 1'b1;
                end
            end
            if ((r_state == pkn_pkg::ST_DIV) && w_div_done) begin
                r_done <= 1'b1;
                r_rptr <= r_rptr + CW'(1);
            end
        end
    end

    // Payload registers and the sample store.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_left  <= i_left_sample;
            r_right <= i_right_sample;
            r_last  <= i_frame_last;
        end
        if (w_mem_we) begin
            r_mem[w_wc_base[AW-1:0]] <= w_value;
        end
        if (r_state == pkn_pkg::ST_READ) begin
            r_rd_data <= r_mem[r_rptr[AW-1:0]];
        end
        if (r_state == pkn_pkg::ST_SETUP) begin
            r_neg <= r_rd_data[VW-1];
        end
        if ((r_state == pkn_pkg::ST_DIV) && w_div_done) begin
            if (w_peak == '0) begin
                r_norm <= '0;
            end else begin
                r_norm <= r_neg ? signed'(-w_quo_ext) : signed'(w_quo_ext);
            end
            r_is_last <= (CW'(r_rptr + CW'(1)) == r_wcount);
        end
    end

    pkn_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_rd_mag),
        .i_divisor  (w_peak),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign w_cnt_ext      = 32'(r_wcount);
    assign o_done         = r_done;
    assign o_norm_sample  = r_norm;
    assign o_is_last      = r_is_last;
    assign o_min_value    = r_min[pkn_pkg::SAMPLE_W-1:0];
    assign o_max_value    = r_max[pkn_pkg::SAMPLE_W-1:0];
    assign o_sample_count = w_cnt_ext[pkn_pkg::COUNT_OUT_W-1:0];
    assign o_overflow     = r_dropped;

`ifndef ASSERT_OFF
    a_done_from_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ($past(r_state) == pkn_pkg::ST_DIV))
        else $error("result word issued outside the divide step");

    a_idle_div_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> !w_div_busy)
        else $error("divider running while the sequencer is idle");

    a_rptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rptr <= r_wcount)
        else $error("read pointer passed the write count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wcount <= CW'(STORE_DEPTH))
        else $error("write count exceeds the store depth");

    a_minmax_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_min <= 0) && (r_max >= 0))
        else $error("running minimum or maximum crossed zero");
`endif

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for peak_normalizer: directed and random load/fetch words.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = 4096;
    localparam int RANDOM_WORDS = 1550;
    localparam int SETTLE_CYCLES = 25;

    typedef struct {
        logic signed [pkn_pkg::NORM_W-1:0]   norm;
        logic                                is_last;
        logic signed [pkn_pkg::SAMPLE_W-1:0] min_v;
        logic [pkn_pkg::SAMPLE_W-1:0]        max_v;
        logic [pkn_pkg::COUNT_OUT_W-1:0]     count;
        logic                                ovf;
    } t_norm_result;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                start = 1'b0;
    logic                                busy;
    logic                                i_cfg_we = 1'b0;
    logic                                i_cfg_wdata = 1'b0;
    logic                                i_req_type = pkn_pkg::REQ_LOAD;
    logic signed [pkn_pkg::SAMPLE_W-1:0] i_left_sample = '0;
    logic signed [pkn_pkg::SAMPLE_W-1:0] i_right_sample = '0;
    logic                                i_frame_last = 1'b0;
    logic                                o_done;
    logic signed [pkn_pkg::NORM_W-1:0]   o_norm_sample;
    logic                                o_is_last;
    logic signed [pkn_pkg::SAMPLE_W-1:0] o_min_value;
    logic [pkn_pkg::SAMPLE_W-1:0]        o_max_value;
    logic [pkn_pkg::COUNT_OUT_W-1:0]     o_sample_count;
    logic                                o_overflow;

    // Predictor state of the normalizer.
    logic signed [pkn_pkg::VALUE_W-1:0]  stored_values [STORE_DEPTH];
    logic signed [pkn_pkg::VALUE_W-1:0]  max_seen;
    logic signed [pkn_pkg::VALUE_W-1:0]  min_seen;
    int                                  stored_count;
    int                                  read_index;
    logic                                set_closed;
    logic                                dropped;
    logic                                stereo_mode;

    t_norm_result                        pending_results [$];
    int                                  err_count = 0;
    int                                  words_sent = 0;
    int                                  max_gap = 0;

    peak_normalizer #(
        .STORE_DEPTH(STORE_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_req_type     (i_req_type),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .i_frame_last   (i_frame_last),
        .o_done         (o_done),
        .o_norm_sample  (o_norm_sample),
        .o_is_last      (o_is_last),
        .o_min_value    (o_min_value),
        .o_max_value    (o_max_value),
        .o_sample_count (o_sample_count),
        .o_overflow     (o_overflow)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int magnitude(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic void clear_set();
        max_seen = '0;
        min_seen = '0;
        stored_count = 0;
        read_index = 0;
        set_closed = 1'b0;
        dropped = 1'b0;
    endfunction

    // Updates the predictor for one accepted word and queues the normalized
    // sample it is expected to produce, if any.
    function automatic void predict_word(input logic req,
                                         input logic signed [pkn_pkg::SAMPLE_W-1:0] left,
                                         input logic signed [pkn_pkg::SAMPLE_W-1:0] right,
                                         input logic last);
        int           v;
        int           peak;
        int           quo;
        int           norm;
        t_norm_result res;
        if (req == pkn_pkg::REQ_LOAD) begin
            if (set_closed) clear_set();
            v = stereo_mode ? (magnitude(int'(left)) + magnitude(int'(right))) / 2
                            : int'(left);
            if (stored_count < STORE_DEPTH) begin
                stored_values[stored_count] = v[pkn_pkg::VALUE_W-1:0];
                stored_count++;
                if (v > max_seen) max_seen = v[pkn_pkg::VALUE_W-1:0];
                if (v < min_seen) min_seen = v[pkn_pkg::VALUE_W-1:0];
            end else begin
                dropped = 1'b1;
            end
            if (last) begin
                set_closed = 1'b1;
                read_index = 0;
            end
            return;
        end
        if (!set_closed || read_index >= stored_count) return;
        v = stored_values[read_index];
        peak = magnitude(int'(min_seen));
        if (magnitude(int'(max_seen)) > peak) peak = magnitude(int'(max_seen));
        norm = 0;
        if (peak != 0) begin
            quo = (magnitude(v) * 32768) / peak;
            norm = (v < 0) ? -quo : quo;
        end
        res.norm = norm[pkn_pkg::NORM_W-1:0];
        res.is_last = (read_index + 1 == stored_count);
        res.min_v = min_seen[pkn_pkg::SAMPLE_W-1:0];
        res.max_v = max_seen[pkn_pkg::SAMPLE_W-1:0];
        res.count = stored_count[pkn_pkg::COUNT_OUT_W-1:0];
        res.ovf = dropped;
        pending_results.push_back(res);
        read_index++;
    endfunction

    function automatic logic signed [pkn_pkg::SAMPLE_W-1:0] random_sample();
        int pick;
        int raw;
        pick = $urandom_range(0, 9);
        if (pick == 0) return {1'b1, {(pkn_pkg::SAMPLE_W-1){1'b0}}};
        if (pick == 1) return {1'b0, {(pkn_pkg::SAMPLE_W-1){1'b1}}};
        if (pick < 4) raw = int'($urandom_range(0, 255)) - 128;
        else raw = int'($urandom);
        return raw[pkn_pkg::SAMPLE_W-1:0];
    endfunction

    task automatic send_word(input logic req,
                             input logic signed [pkn_pkg::SAMPLE_W-1:0] left,
                             input logic signed [pkn_pkg::SAMPLE_W-1:0] right,
                             input logic last);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req_type <= req;
        i_left_sample <= left;
        i_right_sample <= right;
        i_frame_last <= last;
        do @(posedge i_clk); while (busy);
        predict_word(req, left, right, last);
        words_sent++;
    endtask

    // Holds off the sender until every expected word is back and the block
    // has finished any word that returns nothing.
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_stereo_mode(input logic mode);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        stereo_mode = mode;
    endtask

    task automatic test_mono_extremes();
        max_gap = 3;
        set_stereo_mode(1'b0);
        send_word(pkn_pkg::REQ_FETCH, random_sample(), random_sample(), 1'b1);
        send_word(pkn_pkg::REQ_LOAD, 16'sh7fff, random_sample(), 1'b0);
        send_word(pkn_pkg::REQ_LOAD, 16'sh8000, random_sample(), 1'b0);
        send_word(pkn_pkg::REQ_FETCH, random_sample(), random_sample(), 1'b0);
        send_word(pkn_pkg::REQ_LOAD, 16'sh0000, random_sample(), 1'b0);
        send_word(pkn_pkg::REQ_LOAD, 16'shffff, random_sample(), 1'b0);
        send_word(pkn_pkg::REQ_LOAD, 16'sh0001, random_sample(), 1'b1);
        // The sixth fetch comes after the drain and returns nothing.
        repeat (6) send_word(pkn_pkg::REQ_FETCH, random_sample(), random_sample(), 1'b0);
    endtask

    task automatic test_stereo_mix();
        max_gap = 16;
        set_stereo_mode(1'b1);
        send_word(pkn_pkg::REQ_LOAD, 16'sh8000, 16'sh8000, 1'b0);
        send_word(pkn_pkg::REQ_LOAD, 16'sh7fff, 16'sh8000, 1'b0);
        send_word(pkn_pkg::REQ_LOAD, 16'shffff, 16'sh0000, 1'b0);
        send_word(pkn_pkg::REQ_LOAD, 16'sh0005, 16'shfff8, 1'b1);
        // Partial drain; the next load must start a fresh set.
        repeat (3) send_word(pkn_pkg::REQ_FETCH, random_sample(), random_sample(), 1'b1);
    endtask

    task automatic test_zero_peak();
        max_gap = 0;
        set_stereo_mode(1'b0);
        send_word(pkn_pkg::REQ_LOAD, 16'sh0000, random_sample(), 1'b0);
        send_word(pkn_pkg::REQ_LOAD, 16'sh0000, random_sample(), 1'b1);
        repeat (3) send_word(pkn_pkg::REQ_FETCH, random_sample(), random_sample(), 1'b0);
    endtask

    task automatic test_store_full();
        max_gap = 0;
        for (int i = 0; i < STORE_DEPTH + 3; i++)
            send_word(pkn_pkg::REQ_LOAD, random_sample(), random_sample(),
                      i == STORE_DEPTH + 2);
        repeat (STORE_DEPTH + 1)
            send_word(pkn_pkg::REQ_FETCH, random_sample(), random_sample(), 1'b0);
        wait_idle();
    endtask

    task automatic test_random_sets();
        int first_word;
        int set_len;
        int fetch_cnt;
        first_word = words_sent;
        while (words_sent - first_word < RANDOM_WORDS) begin
            if ($urandom_range(0, 5) == 0) begin
                set_stereo_mode(1'($urandom_range(0, 1)));
                max_gap = ($urandom_range(0, 2) == 0) ? 0 : 16;
            end
            if ($urandom_range(0, 9) == 0) begin
                // Noise: random word kinds and random last markers.
                repeat ($urandom_range(1, 8))
                    send_word(1'($urandom_range(0, 1)), random_sample(), random_sample(),
                              $urandom_range(0, 3) == 0);
            end else begin
                set_len = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 120)
                                                       : $urandom_range(1, 12);
                for (int i = 0; i < set_len; i++) begin
                    if ($urandom_range(0, 19) == 0)
                        send_word(pkn_pkg::REQ_FETCH, random_sample(), random_sample(),
                                  1'($urandom_range(0, 1)));
                    send_word(pkn_pkg::REQ_LOAD, random_sample(), random_sample(),
                              i == set_len - 1);
                end
                case ($urandom_range(0, 5))
                    0: fetch_cnt = $urandom_range(0, set_len);
                    1: fetch_cnt = set_len + $urandom_range(1, 3);
                    default: fetch_cnt = set_len;
                endcase
                repeat (fetch_cnt)
                    send_word(pkn_pkg::REQ_FETCH, random_sample(), random_sample(),
                              1'($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 7) == 0) wait_idle();
        end
    endtask

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        t_norm_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $error("result word with none expected");
                err_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("norm_sample", want.norm, o_norm_sample);
                check_field("is_last", want.is_last, o_is_last);
                check_field("min_value", want.min_v, o_min_value);
                check_field("max_value", want.max_v, o_max_value);
                check_field("sample_count", want.count, o_sample_count);
                check_field("overflow", want.ovf, o_overflow);
            end
        end
    end

    initial begin
        int n;
        clear_set();
        stereo_mode = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_mono_extremes();
        test_stereo_mix();
        test_zero_peak();
        test_store_full();
        test_random_sets();
        start <= 1'b0;
        n = 0;
        while (pending_results.size() != 0 && n < 2000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected result words never arrived", pending_results.size());
            err_count++;
        end
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
